@@ rtl/nzic_pkg.sv @@
package nzic_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    CFG_ROW_COUNT   = 2'd0,
    CFG_LIMIT_ON    = 2'd1,
    CFG_LIMIT_COUNT = 2'd2,
    CFG_FROM_END    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] row_count;
    logic        limit_on;
    logic [15:0] limit_count;
    logic        from_end;
  } cfg_t;

  // one hit as it travels and sits in the ring
  typedef struct packed {
    logic signed [31:0] im;
    logic signed [31:0] re;
    logic [31:0]        col;
    logic [15:0]        row;
    logic [31:0]        idx;
  } hit_t;

  // classified word handed from front to back
  typedef struct packed {
    hit_t        val;
    logic        keep;
    logic        keep_last;
    logic        ring_wr;
    logic        last;
    logic        from_end;
    logic        limit_on;
    logic [15:0] limit_count;
  } entry_t;

  typedef struct packed {
    hit_t val;
    logic is_hit;
    logic fin;
  } result_t;

endpackage

@@ rtl/nzic_front.sv @@
module nzic_front
  import nzic_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        full_i,
  output logic        push_o,
  output entry_t      entry_o
);

  localparam int unsigned VW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;

  logic [31:0] elem_cnt_q, elem_cnt_d;
  logic [15:0] row_cnt_q, row_cnt_d;
  logic [31:0] col_cnt_q, col_cnt_d;
  logic [31:0] hit_cnt_q, hit_cnt_d;

  logic [15:0] rows;
  logic [31:0] lim;
  logic [31:0] elem_re, elem_im;
  logic        hit, accept;

  assign elem_re       = s_axis_tdata[31:0];
  assign elem_im       = s_axis_tdata[63:32];
  assign s_axis_tready = ~full_i;
  assign accept        = s_axis_tvalid & ~full_i;

  always_comb begin
    rows = (cfg_i.row_count == 16'd0) ? 16'd1 : cfg_i.row_count;
    hit  = (|elem_re[VW-1:0]) | (|elem_im[VW-1:0]);
    lim  = cfg_i.limit_on ? {16'd0, cfg_i.limit_count} : 32'hFFFF_FFFF;

    entry_o.val.idx     = 32'(elem_cnt_q + 32'd1);
    entry_o.val.row     = row_cnt_q;
    entry_o.val.col     = col_cnt_q;
    entry_o.val.re      = elem_re;
    entry_o.val.im      = elem_im;
    entry_o.ring_wr     = hit & cfg_i.from_end;
    entry_o.keep        = hit & ~cfg_i.from_end & (hit_cnt_q < lim);
    entry_o.keep_last   = entry_o.keep & (32'(hit_cnt_q + 32'd1) == lim);
    entry_o.last        = s_axis_tlast;
    entry_o.from_end    = cfg_i.from_end;
    entry_o.limit_on    = cfg_i.limit_on;
    entry_o.limit_count = cfg_i.limit_count;

    push_o = accept & (hit | s_axis_tlast);

    elem_cnt_d = entry_o.val.idx;
    if (row_cnt_q >= rows) begin
      row_cnt_d = 16'd1;
      col_cnt_d = 32'(col_cnt_q + 32'd1);
    end else begin
      row_cnt_d = 16'(row_cnt_q + 16'd1);
      col_cnt_d = col_cnt_q;
    end
    hit_cnt_d = (hit && hit_cnt_q != 32'hFFFF_FFFF) ? 32'(hit_cnt_q + 32'd1) : hit_cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_cnt_q <= '0;
      row_cnt_q  <= 16'd1;
      col_cnt_q  <= 32'd1;
      hit_cnt_q  <= '0;
    end else if (accept) begin
      if (s_axis_tlast) begin
        elem_cnt_q <= '0;
        row_cnt_q  <= 16'd1;
        col_cnt_q  <= 32'd1;
        hit_cnt_q  <= '0;
      end else begin
        elem_cnt_q <= elem_cnt_d;
        row_cnt_q  <= row_cnt_d;
        col_cnt_q  <= col_cnt_d;
        hit_cnt_q  <= hit_cnt_d;
      end
    end
  end

endmodule

@@ rtl/nzic_queue.sv @@
module nzic_queue
  import nzic_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   head_valid_o,
  output entry_t head_o
);

  entry_t               slot_q [QUEUE_DEPTH];
  logic [QUEUE_PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QUEUE_PW:0]    count_q;

  assign full_o       = (count_q == (QUEUE_PW+1)'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= QUEUE_PW'(wr_ptr_q + 1'b1);
      end
      if (pop_i) begin
        rd_ptr_q <= QUEUE_PW'(rd_ptr_q + 1'b1);
      end
      if (push_i && !pop_i) begin
        count_q <= (QUEUE_PW+1)'(count_q + 1'b1);
      end else if (!push_i && pop_i) begin
        count_q <= (QUEUE_PW+1)'(count_q - 1'b1);
      end
    end
  end

endmodule

@@ rtl/nzic_back.sv @@
module nzic_back
  import nzic_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 32
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    head_valid_i,
  input  entry_t  head_i,
  output logic    pop_o,
  output logic    m_valid_o,
  input  logic    m_ready_i,
  output result_t m_data_o
);

  localparam int unsigned PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_ITEM,
    ST_FLUSH,
    ST_END,
    ST_DRAIN_RD,
    ST_DRAIN
  } state_e;

  state_e        state_q;
  hit_t          ring_q [RING_DEPTH];
  hit_t          rd_q;
  hit_t          pend_q;
  logic          pend_valid_q, emitted_q;
  logic [PW-1:0] wp_q, rp_q, wp_inc, rp_inc, rp_start;
  logic [CW-1:0] fill_q, cnt_q, k_req, k_use;
  logic          last_q, fe_q, lim_on_q;
  logic [15:0]   lim_cnt_q;
  logic [CW:0]   rp_sum;
  logic          out_valid_q;
  result_t       out_q;
  logic          out_free, ring_we, rd_en;

  assign out_free  = ~out_valid_q | m_ready_i;
  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_q;

  always_comb begin
    pop_o = (state_q == ST_ITEM) && head_valid_i
            && (!(head_i.keep && pend_valid_q) || out_free);
    ring_we = pop_o & head_i.ring_wr;
    rd_en   = (state_q == ST_DRAIN_RD);

    wp_inc = (wp_q == PW'(RING_DEPTH - 1)) ? '0 : PW'(wp_q + 1'b1);
    rp_inc = (rp_q == PW'(RING_DEPTH - 1)) ? '0 : PW'(rp_q + 1'b1);

    if (!lim_on_q || lim_cnt_q > 16'(RING_DEPTH)) begin
      k_req = CW'(RING_DEPTH);
    end else begin
      k_req = CW'(lim_cnt_q);
    end
    k_use = (k_req > fill_q) ? fill_q : k_req;

    rp_sum = (CW+1)'((CW+1)'(wp_q) + (CW+1)'(RING_DEPTH) - (CW+1)'(k_use));
    if (rp_sum >= (CW+1)'(RING_DEPTH)) begin
      rp_start = PW'(rp_sum - (CW+1)'(RING_DEPTH));
    end else begin
      rp_start = PW'(rp_sum);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_q[wp_q] <= head_i.val;
    end
    if (rd_en) begin
      rd_q <= ring_q[rp_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_ITEM;
      pend_q       <= '0;
      pend_valid_q <= 1'b0;
      emitted_q    <= 1'b0;
      wp_q         <= '0;
      rp_q         <= '0;
      fill_q       <= '0;
      cnt_q        <= '0;
      last_q       <= 1'b0;
      fe_q         <= 1'b0;
      lim_on_q     <= 1'b0;
      lim_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_ITEM: begin
          if (pop_o) begin
            last_q    <= head_i.last;
            fe_q      <= head_i.from_end;
            lim_on_q  <= head_i.limit_on;
            lim_cnt_q <= head_i.limit_count;
            if (head_i.ring_wr) begin
              wp_q <= wp_inc;
              if (fill_q != CW'(RING_DEPTH)) begin
                fill_q <= CW'(fill_q + 1'b1);
              end
            end
            if (head_i.keep) begin
              if (pend_valid_q) begin
                out_valid_q <= 1'b1;
                out_q       <= '{val: pend_q, is_hit: 1'b1, fin: 1'b0};
              end
              pend_q       <= head_i.val;
              pend_valid_q <= 1'b1;
              emitted_q    <= 1'b1;
            end
            if (head_i.keep && head_i.keep_last) begin
              state_q <= ST_FLUSH;
            end else if (head_i.last) begin
              state_q <= ST_END;
            end
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_q        <= '{val: pend_q, is_hit: 1'b1, fin: 1'b1};
            pend_valid_q <= 1'b0;
            state_q      <= last_q ? ST_END : ST_ITEM;
          end
        end
        ST_END: begin
          if (!fe_q && pend_valid_q) begin
            state_q <= ST_FLUSH;
          end else if (fe_q && k_use != '0) begin
            rp_q    <= rp_start;
            cnt_q   <= k_use;
            state_q <= ST_DRAIN_RD;
          end else if (emitted_q || out_free) begin
            // empty array: one marker word
            if (!emitted_q) begin
              out_valid_q <= 1'b1;
              out_q       <= '{val: '0, is_hit: 1'b0, fin: 1'b1};
            end
            wp_q         <= '0;
            fill_q       <= '0;
            pend_valid_q <= 1'b0;
            emitted_q    <= 1'b0;
            state_q      <= ST_ITEM;
          end
        end
        ST_DRAIN_RD: begin
          rp_q    <= rp_inc;
          state_q <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_q       <= '{val: rd_q, is_hit: 1'b1, fin: (cnt_q == CW'(1))};
            cnt_q       <= CW'(cnt_q - 1'b1);
            if (cnt_q == CW'(1)) begin
              wp_q         <= '0;
              fill_q       <= '0;
              pend_valid_q <= 1'b0;
              emitted_q    <= 1'b0;
              state_q      <= ST_ITEM;
            end else begin
              state_q <= ST_DRAIN_RD;
            end
          end
        end
        default: state_q <= ST_ITEM;
      endcase
    end
  end

endmodule

@@ rtl/nonzero_index_compaction.sv @@
// Finds the nonzero elements of a column-major array streamed one word per
// element. Input word: real and imaginary parts, tlast on the array's last
// element. Each output word carries one kept hit (1-based linear index, row,
// column, value) with tuser high, or the empty-array marker with tuser low;
// tlast marks the last output word of an array.
// Registers are written through cfg_we_i / cfg_addr_i / cfg_wdata_i: row
// count, limit enable, limit count, from-end mode. The user must write them
// only while the block is idle; the block itself does not enforce this.
// A result passes through the queue and the output register; in keep-first
// mode a hit is held back until the next kept hit or the array end, so that
// tlast can be set on it.
// Throughput: one element per cycle while the back pops one queued word per
// cycle. An entry that reaches the limit also passes through a flush state,
// every array end through an end state (and the flush state too when a held
// hit is sent then); in from-end mode the end state sets up a drain of up to
// RING_DEPTH ring entries, each read from the ring and then output.
// A four-word queue between front and back absorbs the time in these states;
// when it fills, s_axis_tready drops. When the receiver stalls, the output
// register holds its word and the back stops at its next word to send. Reset
// sets counters, pointers and registers to defaults; no clearing pass needed.
module nonzero_index_compaction
  import nzic_pkg::*;
#(
  parameter int unsigned RING_DEPTH  = 32,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,  // elem_real, elem_imag
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [143:0] m_axis_tdata,  // linear_index, row_number, column_number, hit_real, hit_imag
  output logic         m_axis_tuser,  // is_hit
  output logic         m_axis_tlast,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_addr_i,
  input  logic [15:0]  cfg_wdata_i
);

  cfg_t    cfg_q;
  logic    push, full, pop, head_valid;
  entry_t  entry, head;
  result_t result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_count   <= 16'd1;
      cfg_q.limit_on    <= 1'b0;
      cfg_q.limit_count <= '0;
      cfg_q.from_end    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CFG_ROW_COUNT:   cfg_q.row_count   <= cfg_wdata_i;
        CFG_LIMIT_ON:    cfg_q.limit_on    <= cfg_wdata_i[0];
        CFG_LIMIT_COUNT: cfg_q.limit_count <= cfg_wdata_i;
        CFG_FROM_END:    cfg_q.from_end    <= cfg_wdata_i[0];
        default:         cfg_q             <= cfg_q;
      endcase
    end
  end

  nzic_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .full_i        (full),
    .push_o        (push),
    .entry_o       (entry)
  );

  nzic_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (entry),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  nzic_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_o     (result)
  );

  assign m_axis_tdata = {result.val.im, result.val.re, result.val.col,
                         result.val.row, result.val.idx};
  assign m_axis_tuser = result.is_hit;
  assign m_axis_tlast = result.fin;

endmodule

@@ bench/nzic_hit_checker.sv @@
module nzic_hit_checker
  import nzic_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,  // elem_real, elem_imag
  input  logic         s_axis_tlast,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [143:0] m_axis_tdata,  // linear_index, row_number, column_number, hit_real, hit_imag
  input  logic         m_axis_tuser,  // is_hit
  input  logic         m_axis_tlast,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_addr_i,
  input  logic [15:0]  cfg_wdata_i,
  output int           failures_o,
  output int           outstanding_o
);

  logic [15:0] row_count_r;
  logic [15:0] limit_count_r;
  logic        limit_on_r;
  logic        from_end_r;

  logic [31:0] element_cnt;
  logic [15:0] row_cnt;
  logic [31:0] column_cnt;
  logic [31:0] hit_cnt;
  hit_t        ring [RING_DEPTH];
  int unsigned ring_wr;
  int unsigned ring_used;
  logic        held_valid;
  hit_t        held;
  logic        produced;

  result_t     expected_hits [$];
  int          failures = 0;

  task automatic clear_array();
    element_cnt = '0;
    row_cnt     = 16'd1;
    column_cnt  = 32'd1;
    hit_cnt     = '0;
    ring_wr     = 0;
    ring_used   = 0;
    held_valid  = 1'b0;
    produced    = 1'b0;
  endtask

  task automatic queue_result(input hit_t v, input logic is_hit, input logic fin);
    result_t r;
    r.val    = v;
    r.is_hit = is_hit;
    r.fin    = fin;
    expected_hits.insert(expected_hits.size(), r);
  endtask

  task automatic find_hits(input logic [31:0] re, input logic [31:0] im, input logic last);
    hit_t        cur;
    logic [15:0] rows;
    logic [31:0] lim;
    int unsigned k;
    int unsigned p;
    cur.idx = element_cnt + 32'd1;
    cur.row = row_cnt;
    cur.col = column_cnt;
    cur.re  = re;
    cur.im  = im;
    rows = (row_count_r == 16'd0) ? 16'd1 : row_count_r;
    element_cnt = cur.idx;
    if (row_cnt >= rows) begin
      row_cnt    = 16'd1;
      column_cnt = column_cnt + 32'd1;
    end else begin
      row_cnt = row_cnt + 16'd1;
    end

    if (re != '0 || im != '0) begin
      if (from_end_r) begin
        ring[ring_wr] = cur;
        ring_wr = (ring_wr + 1) % RING_DEPTH;
        if (ring_used < RING_DEPTH) ring_used++;
      end else begin
        lim = limit_on_r ? {16'd0, limit_count_r} : 32'hFFFF_FFFF;
        if (hit_cnt < lim) begin
          if (held_valid) queue_result(held, 1'b1, 1'b0);
          if (hit_cnt + 32'd1 == lim) begin
            queue_result(cur, 1'b1, 1'b1);
            held_valid = 1'b0;
          end else begin
            held_valid = 1'b1;
            held       = cur;
          end
          produced = 1'b1;
        end
      end
      if (hit_cnt != 32'hFFFF_FFFF) hit_cnt = hit_cnt + 32'd1;
    end

    if (last) begin
      if (from_end_r) begin
        k = limit_on_r ? int'(limit_count_r) : RING_DEPTH;
        if (k > RING_DEPTH) k = RING_DEPTH;
        if (k > ring_used) k = ring_used;
        for (int unsigned i = 0; i < k; i++) begin
          p = (ring_wr + RING_DEPTH - k + i) % RING_DEPTH;
          queue_result(ring[p], 1'b1, (i + 1 == k));
          produced = 1'b1;
        end
      end else if (held_valid) begin
        queue_result(held, 1'b1, 1'b1);
        produced = 1'b1;
      end
      if (!produced) queue_result('0, 1'b0, 1'b1);
      clear_array();
    end
  endtask

  task automatic note_failure(input string what, input result_t want, input result_t got);
    failures++;
    if (failures <= 10)
      $display({"%s: want idx=%0d row=%0d col=%0d re=%h im=%h hit=%b last=%b, ",
                "got idx=%0d row=%0d col=%0d re=%h im=%h hit=%b last=%b"},
               what, want.val.idx, want.val.row, want.val.col, want.val.re, want.val.im,
               want.is_hit, want.fin, got.val.idx, got.val.row, got.val.col, got.val.re,
               got.val.im, got.is_hit, got.fin);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      row_count_r   = 16'd1;
      limit_on_r    = 1'b0;
      limit_count_r = 16'd0;
      from_end_r    = 1'b0;
      clear_array();
      expected_hits.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_addr_i))
          CFG_ROW_COUNT:   row_count_r   = cfg_wdata_i;
          CFG_LIMIT_ON:    limit_on_r    = cfg_wdata_i[0];
          CFG_LIMIT_COUNT: limit_count_r = cfg_wdata_i;
          CFG_FROM_END:    from_end_r    = cfg_wdata_i[0];
          default: ;
        endcase
      end

      if (m_axis_tvalid && m_axis_tready) begin
        got.val.idx = m_axis_tdata[31:0];
        got.val.row = m_axis_tdata[47:32];
        got.val.col = m_axis_tdata[79:48];
        got.val.re  = m_axis_tdata[111:80];
        got.val.im  = m_axis_tdata[143:112];
        got.is_hit  = m_axis_tuser;
        got.fin     = m_axis_tlast;
        if (expected_hits.size() == 0) begin
          note_failure("unexpected word", '0, got);
        end else begin
          want = expected_hits.pop_front();
          if (got.val.idx !== want.val.idx || got.val.row !== want.val.row ||
              got.val.col !== want.val.col || got.val.re !== want.val.re ||
              got.val.im !== want.val.im || got.is_hit !== want.is_hit ||
              got.fin !== want.fin)
            note_failure("word mismatch", want, got);
        end
      end

      if (s_axis_tvalid && s_axis_tready)
        find_hits(s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tlast);
    end
    failures_o    <= failures;
    outstanding_o <= expected_hits.size();
  end

endmodule

@@ bench/tb_nonzero_index_compaction.sv @@
module tb_nonzero_index_compaction;
  import nzic_pkg::*;

  typedef enum int {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_e;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [143:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_addr_i = '0;
  logic [15:0]  cfg_wdata_i = '0;
  int           failures;
  int           outstanding;

  int           burst_left = 0;
  int           elements_sent = 0;
  rx_mode_e     rx_mode = RX_OPEN;
  int           rx_tick = 0;

  always #5 clk_i = ~clk_i;

  nonzero_index_compaction uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  nzic_hit_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .failures_o    (failures),
    .outstanding_o (outstanding)
  );

  // receiver back-pressure in one of four randomly chosen modes
  always @(posedge clk_i) begin
    rx_tick = rx_tick + 1;
    if (rx_tick % 50 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:  m_axis_tready <= 1'b1;
      RX_LIGHT: m_axis_tready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default:  m_axis_tready <= (rx_tick % 8 < 3);
    endcase
  end

  initial begin
    #2000000;
    $display("[nonzero_index_compaction] ERROR");
    $finish;
  end

  task automatic send_element(input logic [31:0] re, input logic [31:0] im, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {im, re};
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    elements_sent++;
  endtask

  // drain everything in flight, then give held words time to settle
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [15:0] rows, input logic lim_on,
                                input logic [15:0] lim_cnt, input logic fe);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CFG_ROW_COUNT;
    cfg_wdata_i <= rows;
    @(posedge clk_i);
    cfg_addr_i  <= CFG_LIMIT_ON;
    cfg_wdata_i <= {15'd0, lim_on};
    @(posedge clk_i);
    cfg_addr_i  <= CFG_LIMIT_COUNT;
    cfg_wdata_i <= lim_cnt;
    @(posedge clk_i);
    cfg_addr_i  <= CFG_FROM_END;
    cfg_wdata_i <= {15'd0, fe};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 32'd0;
    else if (r < 34) return 32'h7FFF_FFFF;
    else if (r < 38) return 32'h8000_0000;
    else if (r < 42) return 32'hFFFF_FFFF;
    else if (r < 46) return 32'd1;
    else return $urandom();
  endfunction

  task automatic send_array(input int len, input int zero_pct, input logic close);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < zero_pct)
        send_element(32'd0, 32'd0, close && (i == len - 1));
      else
        send_element(pick_word(), pick_word(), close && (i == len - 1));
    end
  endtask

  initial begin
    logic [15:0] rows;
    logic [15:0] lim_cnt;
    int          len;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: empty array, then extremes of the words
    send_element(32'd0, 32'd0, 1'b1);
    send_element(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_element(32'd0, 32'd0, 1'b0);
    send_element(32'd0, 32'd1, 1'b0);
    send_element(32'hFFFF_FFFF, 32'd0, 1'b1);
    settle();

    // limit reached mid-array, later hits ignored
    apply_settings(16'd3, 1'b1, 16'd2, 1'b0);
    send_element(32'd1, 32'd0, 1'b0);
    send_element(32'd0, 32'd2, 1'b0);
    send_element(32'd3, 32'd3, 1'b0);
    send_element(32'd0, 32'd0, 1'b0);
    send_element(32'd4, 32'd0, 1'b0);
    send_element(32'd0, 32'd0, 1'b0);
    send_element(32'd5, 32'd0, 1'b1);
    settle();

    // zero rows, limit of zero gives the marker
    apply_settings(16'd0, 1'b1, 16'd0, 1'b0);
    send_element(32'd1, 32'd0, 1'b0);
    send_element(32'd0, 32'd2, 1'b1);
    settle();

    // from end with a limit above the ring depth
    apply_settings(16'd2, 1'b1, 16'hFFFF, 1'b1);
    send_element(32'd3, 32'd0, 1'b0);
    send_element(32'd0, 32'd0, 1'b0);
    send_element(32'd0, 32'hFFFF_FFFF, 1'b0);
    send_element(32'd9, 32'd9, 1'b0);
    send_element(32'd0, 32'd0, 1'b1);
    settle();

    // held hit dropped when the array ends after a switch to from-end
    apply_settings(16'hFFFF, 1'b0, 16'd1, 1'b0);
    send_element(32'd5, 32'd5, 1'b0);
    send_element(32'd0, 32'd0, 1'b0);
    send_element(32'd6, 32'd0, 1'b0);
    settle();
    apply_settings(16'hFFFF, 1'b0, 16'd1, 1'b1);
    send_element(32'd0, 32'd7, 1'b0);
    send_element(32'd0, 32'd0, 1'b1);
    settle();

    while (elements_sent < 198) begin
      case ($urandom_range(0, 5))
        0:       rows = 16'd0;
        1:       rows = 16'd1;
        2:       rows = 16'hFFFF;
        default: rows = 16'($urandom_range(2, 8));
      endcase
      case ($urandom_range(0, 4))
        0:       lim_cnt = 16'd0;
        1:       lim_cnt = 16'hFFFF;
        2:       lim_cnt = 16'd1;
        default: lim_cnt = 16'($urandom_range(2, 40));
      endcase
      apply_settings(rows, 1'($urandom_range(0, 1)), lim_cnt, 1'($urandom_range(0, 1)));
      repeat ($urandom_range(1, 3)) begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(33, 48) : $urandom_range(1, 10);
        send_array(len, $urandom_range(0, 90), 1'b1);
      end
      // leave an array open across the next settings change
      if ($urandom_range(0, 3) == 0) send_array($urandom_range(1, 5), 30, 1'b0);
      settle();
    end

    if (failures == 0) begin
      $display("[nonzero_index_compaction] OK");
    end else begin
      $display("[nonzero_index_compaction] ERROR");
    end
    $finish;
  end

endmodule
